### sv/urbq_pkg.sv
// Shared definitions for the UART ring buffer queues block.
// Holds default ring depths, action and result kind codes, and the control structs.
// Depends on nothing.
`default_nettype none

package urbq_pkg;

    localparam int TX_DEPTH_DEF = 64;
    localparam int RX_DEPTH_DEF = 128;

    // Event codes carried on the action field.
    localparam logic [2:0] ACT_HOST_WRITE = 3'd0;
    localparam logic [2:0] ACT_HOST_READ  = 3'd1;
    localparam logic [2:0] ACT_PEEK       = 3'd2;
    localparam logic [2:0] ACT_LINE_RECV  = 3'd3;
    localparam logic [2:0] ACT_TX_READY   = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_HOST   = 2'd2;

    localparam logic [7:0] EMPTY_READ_BYTE = 8'h55;

    typedef struct packed {
        logic push;
        logic pop;
        logic set_active;
        logic clr_active;
    } t_tx_ctl;

    typedef struct packed {
        logic push;
        logic pop;
        logic peek;
    } t_rx_ctl;

endpackage

`default_nettype wire

### sv/urbq_tx_queue.sv
// Transmit ring: byte memory with head and tail pointers, free-space count
// and the transmitter active flag. Uses urbq_pkg for its control struct.
`default_nettype none

module urbq_tx_queue #(
    parameter int  DEPTH = urbq_pkg::TX_DEPTH_DEF,
    localparam int PW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire urbq_pkg::t_tx_ctl  i_ctl,
    input  wire logic [7:0]         i_data,
    output logic [7:0]              o_rd_data,
    output logic [CW-1:0]           o_space,
    output logic                    o_active
);
    import urbq_pkg::*;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rd;
    logic [PW-1:0] r_head, r_tail;
    logic [PW-1:0] n_head, n_tail;
    logic [CW-1:0] r_space;
    logic          r_active;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign n_head = f_next(r_head);
    assign n_tail = f_next(r_tail);

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_head] <= i_data;
        end
        if (i_ctl.pop) begin
            r_rd <= mem[r_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_space  <= CW'(DEPTH);
            r_active <= 1'b0;
        end else begin
            if (i_ctl.push) begin
                r_head  <= n_head;
                r_space <= r_space - 1'b1;
            end else if (i_ctl.pop) begin
                r_tail  <= n_tail;
                r_space <= r_space + 1'b1;
            end
            if (i_ctl.set_active) begin
                r_active <= 1'b1;
            end else if (i_ctl.clr_active) begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_rd_data = r_rd;
    assign o_space   = r_space;
    assign o_active  = r_active;

endmodule

`default_nettype wire

### sv/urbq_rx_queue.sv
// Receive ring: byte memory with per-entry valid bits so unwritten entries
// read as zero, plus head and tail pointers and the fill count. Uses urbq_pkg.
`default_nettype none

module urbq_rx_queue #(
    parameter int  DEPTH = urbq_pkg::RX_DEPTH_DEF,
    localparam int PW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire urbq_pkg::t_rx_ctl  i_ctl,
    input  wire logic [7:0]         i_data,
    output logic [7:0]              o_rd_data,
    output logic [CW-1:0]           o_count
);
    import urbq_pkg::*;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       r_rd;
    logic             r_rd_vld;
    logic [DEPTH-1:0] r_vld;
    logic [PW-1:0]    r_head, r_tail;
    logic [PW-1:0]    n_head, n_tail;
    logic [CW-1:0]    r_count;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign n_head = f_next(r_head);
    assign n_tail = f_next(r_tail);

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_head] <= i_data;
        end
        if (i_ctl.pop || i_ctl.peek) begin
            r_rd <= mem[r_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.pop || i_ctl.peek) begin
                r_rd_vld <= r_vld[r_tail];
            end
            if (i_ctl.push) begin
                r_vld[r_head] <= 1'b1;
                r_head        <= n_head;
                r_count       <= r_count + 1'b1;
            end else if (i_ctl.pop) begin
                r_tail  <= n_tail;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // An entry never written since reset reads as zero.
    assign o_rd_data = r_rd_vld ? r_rd : 8'h00;
    assign o_count   = r_count;

endmodule

`default_nettype wire

### sv/uart_ring_buffer_queues.sv
// Top level of the UART ring buffer queues: event decode and result register.
// Instantiates urbq_tx_queue and urbq_rx_queue; uses urbq_pkg.
//
// Usage:
// The host side and the line side both present events on one command channel:
// an event transfer happens at a rising edge where i_start is high and o_busy
// is low. o_busy is always low, so one event can be taken every cycle.
// i_action selects host write, host read, peek, line byte received or
// transmitter ready; i_data carries the byte for a write or a receive.
// i_framing_error is accepted with the event but has no effect: a byte with a
// framing error is stored like any other.
// Each event produces exactly one result, shown on the o_ result ports for one
// cycle with o_valid high, in the cycle right after the event transfer
// (throughput one event per cycle). The result comes from the result register
// and from the synchronous read port of the ring memories.
// Every result carries the transmit free space and receive count after the
// event, and o_rx_dropped flags a received byte lost to a full receive ring.
// The receiver cannot stall, so a result is gone after its cycle.
// Reset is synchronous: pointers, counts, the transmitter flag and the receive
// valid bits clear at once, and events are taken in the next cycle.
`default_nettype none

module uart_ring_buffer_queues #(
    parameter int  TX_DEPTH = urbq_pkg::TX_DEPTH_DEF,
    parameter int  RX_DEPTH = urbq_pkg::RX_DEPTH_DEF,
    localparam int TX_CW    = $clog2(TX_DEPTH + 1),
    localparam int RX_CW    = $clog2(RX_DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire logic [2:0]       i_action,
    input  wire logic [7:0]       i_data,
    input  wire logic             i_framing_error,
    output logic                  o_valid,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_byte_out,
    output logic [TX_CW-1:0]      o_tx_free,
    output logic [RX_CW-1:0]      o_rx_count,
    output logic                  o_rx_dropped
);
    import urbq_pkg::*;

    // Where the result byte comes from in the result cycle.
    localparam logic [1:0] SRC_DIRECT = 2'd0;
    localparam logic [1:0] SRC_TX     = 2'd1;
    localparam logic [1:0] SRC_RX     = 2'd2;

    logic             accept;
    t_tx_ctl          tx_ctl;
    t_rx_ctl          rx_ctl;
    logic [7:0]       tx_rd_data, rx_rd_data;
    logic [TX_CW-1:0] tx_space;
    logic [RX_CW-1:0] rx_count;
    logic             tx_active;
    logic             tx_full, tx_empty, rx_full, rx_empty;

    logic             r_valid, r_dropped;
    logic [1:0]       r_kind, r_src;
    logic [7:0]       r_byte;
    logic             n_dropped;
    logic [1:0]       n_kind, n_src;
    logic [7:0]       n_byte;

    // Every event finishes in one pass through the rings, so nothing ever
    // holds the command channel off.
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    assign tx_full  = (tx_space == '0);
    assign tx_empty = (tx_space == TX_CW'(TX_DEPTH));
    assign rx_full  = (rx_count == RX_CW'(RX_DEPTH));
    assign rx_empty = (rx_count == '0);

    // Event decode. Each event touches at most one port of each ring, so two
    // events in consecutive cycles never collide on a memory access: a write
    // lands at one edge and any later read of that entry sees it.
    always_comb begin
        tx_ctl    = '0;
        rx_ctl    = '0;
        n_kind    = KIND_STATUS;
        n_src     = SRC_DIRECT;
        n_byte    = 8'h00;
        n_dropped = 1'b0;
        if (accept) begin
            case (i_action)
                ACT_HOST_WRITE: begin
                    // A full transmit ring drops the byte before anything else.
                    if (!tx_full) begin
                        tx_ctl.set_active = 1'b1;
                        if (!tx_active) begin
                            n_kind = KIND_LINE;
                            n_byte = i_data;
                        end else begin
                            tx_ctl.push = 1'b1;
                        end
                    end
                end
                ACT_HOST_READ: begin
                    n_kind = KIND_HOST;
                    if (rx_empty) begin
                        n_byte = EMPTY_READ_BYTE;
                    end else begin
                        rx_ctl.pop = 1'b1;
                        n_src      = SRC_RX;
                    end
                end
                ACT_PEEK: begin
                    // The tail entry is returned even when the ring is empty.
                    n_kind      = KIND_HOST;
                    rx_ctl.peek = 1'b1;
                    n_src       = SRC_RX;
                end
                ACT_LINE_RECV: begin
                    if (rx_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        rx_ctl.push = 1'b1;
                    end
                end
                ACT_TX_READY: begin
                    if (!tx_empty) begin
                        tx_ctl.pop = 1'b1;
                        n_kind     = KIND_LINE;
                        n_src      = SRC_TX;
                    end else begin
                        tx_ctl.clr_active = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    urbq_tx_queue #(
        .DEPTH (TX_DEPTH)
    ) u_tx_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tx_ctl),
        .i_data    (i_data),
        .o_rd_data (tx_rd_data),
        .o_space   (tx_space),
        .o_active  (tx_active)
    );

    urbq_rx_queue #(
        .DEPTH (RX_DEPTH)
    ) u_rx_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (rx_ctl),
        .i_data    (i_data),
        .o_rd_data (rx_rd_data),
        .o_count   (rx_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_src     <= n_src;
        r_byte    <= n_byte;
        r_dropped <= n_dropped;
    end

    // The ring counters already hold the values after the event when the
    // result is shown, and stay put until the next event transfer.
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_byte_out   = (r_src == SRC_TX) ? tx_rd_data :
                          (r_src == SRC_RX) ? rx_rd_data : r_byte;
    assign o_tx_free    = tx_space;
    assign o_rx_count   = rx_count;
    assign o_rx_dropped = r_dropped;

    // Each event transfer is answered by exactly one result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("event transfer without a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_valid)
        else $error("result without an event transfer");

    // A dropped receive byte means the receive ring was full and stays full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rx_dropped) |-> (o_rx_count == RX_CW'(RX_DEPTH)))
        else $error("receive byte dropped with room in the ring");

    // Transmit free space never exceeds the ring depth.
    a_tx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_free <= TX_CW'(TX_DEPTH))
        else $error("transmit free space above depth");

    // A byte read from the transmit ring only follows while the transmitter runs.
    a_tx_send_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_src == SRC_TX)) |-> tx_active)
        else $error("queued byte sent while transmitter idle");

endmodule

`default_nettype wire
